>>> rtl/core/kpld_pkg.sv
// Shared types and constants for the key press / long-press detector.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package kpld_pkg;

  localparam int KPLD_NUM_KEYS = 4;   // default key count
  localparam int KPLD_PIN_W    = 4;   // width of the pin-level field
  localparam int KPLD_MASK_W   = 4;   // width of each event mask
  localparam int KPLD_TICK_W   = 32;
  localparam int KPLD_DATA_W   = 32;
  localparam int KPLD_ADDR_W   = 4;

  localparam logic [KPLD_TICK_W-1:0] KPLD_DEBOUNCE_RST = 32'd20;
  localparam logic [KPLD_TICK_W-1:0] KPLD_LONG_RST     = 32'd1000;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_ACTIVE_HIGH = 2'd0,
    REG_DEBOUNCE_EN = 2'd1,
    REG_DEBOUNCE_TK = 2'd2,
    REG_LONG_TK     = 2'd3
  } reg_idx_t;

  // per-key phase, one-hot
  typedef enum logic [3:0] {
    PH_RELEASED = 4'b0001,
    PH_PREPRESS = 4'b0010,
    PH_PRESSED  = 4'b0100,
    PH_LONG     = 4'b1000
  } phase_t;

  // timing settings shared by every lane
  typedef struct packed {
    logic                   debounce_en;
    logic [KPLD_TICK_W-1:0] debounce_ticks;
    logic [KPLD_TICK_W-1:0] long_ticks;
  } cfg_t;

  // events one lane reports for one scan
  typedef struct packed {
    logic press;
    logic release_ev;
    logic long_ev;
  } evt_t;

endpackage

>>> rtl/core/kpld_lane.sv
// One key lane: phase machine and timestamp for a single key.
// Depends on kpld_pkg.
module kpld_lane (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            scan_fire,
  input  logic                            level,
  input  logic                            polarity,
  input  logic [kpld_pkg::KPLD_TICK_W-1:0] now_tick,
  input  kpld_pkg::cfg_t                  cfg,
  output kpld_pkg::evt_t                  evt
);

  kpld_pkg::phase_t                 phase_r, phase_nxt;
  logic [kpld_pkg::KPLD_TICK_W-1:0] stamp_r, stamp_nxt;
  logic [kpld_pkg::KPLD_TICK_W-1:0] elapsed;
  logic                             down;

  assign down    = (level == polarity);
  assign elapsed = now_tick - stamp_r;

  always_comb begin
    phase_nxt      = phase_r;
    stamp_nxt      = stamp_r;
    evt            = '0;
    case (phase_r)
      kpld_pkg::PH_RELEASED: begin
        if (down) begin
          stamp_nxt = now_tick;
          if (cfg.debounce_en) begin
            phase_nxt = kpld_pkg::PH_PREPRESS;
          end else begin
            phase_nxt = kpld_pkg::PH_PRESSED;
            evt.press = 1'b1;
          end
        end
      end
      kpld_pkg::PH_PREPRESS: begin
        if (!down) begin
          // bounce: drop back, stamp kept
          phase_nxt = kpld_pkg::PH_RELEASED;
        end else if (elapsed > cfg.debounce_ticks) begin
          phase_nxt = kpld_pkg::PH_PRESSED;
          stamp_nxt = now_tick;
          evt.press = 1'b1;
        end
      end
      kpld_pkg::PH_PRESSED,
      kpld_pkg::PH_LONG: begin
        if (!down) begin
          phase_nxt      = kpld_pkg::PH_RELEASED;
          stamp_nxt      = '0;
          evt.release_ev = 1'b1;
        end else if (phase_r == kpld_pkg::PH_PRESSED && elapsed > cfg.long_ticks) begin
          phase_nxt   = kpld_pkg::PH_LONG;
          stamp_nxt   = now_tick;
          evt.long_ev = 1'b1;
        end
      end
      default: begin
        phase_nxt = kpld_pkg::PH_RELEASED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= kpld_pkg::PH_RELEASED;
      stamp_r <= '0;
    end else if (scan_fire) begin
      phase_r <= phase_nxt;
      stamp_r <= stamp_nxt;
    end
  end

`ifndef SYNTH
  a_long_enters_long: assert property (@(posedge clk) disable iff (!rst_n)
    scan_fire && evt.long_ev |=> phase_r == kpld_pkg::PH_LONG)
    else $error("long press reported without entering long phase");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    scan_fire && evt.release_ev |=> phase_r == kpld_pkg::PH_RELEASED && stamp_r == '0)
    else $error("release left phase or stamp uncleared");

  a_press_stamps: assert property (@(posedge clk) disable iff (!rst_n)
    scan_fire && evt.press |=> phase_r == kpld_pkg::PH_PRESSED && stamp_r == $past(now_tick))
    else $error("press not stamped with scan tick");
`endif

endmodule

>>> rtl/core/kpld_merge.sv
// Merge stage: gathers lane events into masks and holds results in an output
// register plus one skid entry. Depends on kpld_pkg.
module kpld_merge #(
  parameter int NUM_KEYS = kpld_pkg::KPLD_NUM_KEYS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             scan_fire,
  input  kpld_pkg::evt_t [NUM_KEYS-1:0]    lane_evt,
  output logic                             skid_full,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [kpld_pkg::KPLD_MASK_W-1:0] out_pressed_mask,
  output logic [kpld_pkg::KPLD_MASK_W-1:0] out_released_mask,
  output logic [kpld_pkg::KPLD_MASK_W-1:0] out_long_mask
);

  localparam int MW = kpld_pkg::KPLD_MASK_W;

  logic [MW-1:0] p_mask, r_mask, l_mask;
  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  logic [MW-1:0] out_p_r, out_r_r, out_l_r;
  logic [MW-1:0] skid_p_r, skid_r_r, skid_l_r;
  logic          out_fire;
  logic          load_out_new, load_out_skid, load_skid;

  // keys beyond the mask width are dropped
  for (genvar i = 0; i < MW; i++) begin : g_mask
    if (i < NUM_KEYS) begin : g_key
      assign p_mask[i] = lane_evt[i].press;
      assign r_mask[i] = lane_evt[i].release_ev;
      assign l_mask[i] = lane_evt[i].long_ev;
    end else begin : g_none
      assign p_mask[i] = 1'b0;
      assign r_mask[i] = 1'b0;
      assign l_mask[i] = 1'b0;
    end
  end

  assign out_fire = out_valid_r & ~out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_out_new   = 1'b0;
    load_out_skid  = 1'b0;
    load_skid      = 1'b0;
    if (out_fire || !out_valid_r) begin
      if (skid_valid_r) begin
        load_out_skid  = 1'b1;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        load_out_new  = scan_fire;
        out_valid_nxt = scan_fire;
      end
    end else if (scan_fire) begin
      load_skid      = 1'b1;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_skid) begin
      out_p_r <= skid_p_r;
      out_r_r <= skid_r_r;
      out_l_r <= skid_l_r;
    end else if (load_out_new) begin
      out_p_r <= p_mask;
      out_r_r <= r_mask;
      out_l_r <= l_mask;
    end
    if (load_skid) begin
      skid_p_r <= p_mask;
      skid_r_r <= r_mask;
      skid_l_r <= l_mask;
    end
  end

  assign skid_full         = skid_valid_r;
  assign out_valid         = out_valid_r;
  assign out_pressed_mask  = out_p_r;
  assign out_released_mask = out_r_r;
  assign out_long_mask     = out_l_r;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_stalled_scan_parks: assert property (@(posedge clk) disable iff (!rst_n)
    scan_fire && out_valid_r && out_stall |=> skid_valid_r)
    else $error("transaction lost while output stalled");

  a_no_fire_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !scan_fire)
    else $error("scan accepted with skid entry occupied");
`endif

endmodule

>>> rtl/core/key_press_long_press_detector_unit.sv
// Key press / long-press detector, top level.
// Event masks of an accepted scan are registered in the merge output register (or its skid entry) and shown on out_*.
// Throughput: one scan per cycle while the skid entry is free (in_stall low); every key has its own lane, so the
//   per-key timestamp subtract-and-compare is the longest path and sets the cycle.
// Reset (rst_n low, synchronous): every key released, timestamps zero, registers to
//   active_high_mask 0, debounce_enable 0, debounce_ticks 20, long_press_ticks 1000.
module key_press_long_press_detector_unit #(
  parameter int NUM_KEYS = kpld_pkg::KPLD_NUM_KEYS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // scan input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [kpld_pkg::KPLD_PIN_W-1:0]  in_pin_levels,
  input  logic [kpld_pkg::KPLD_TICK_W-1:0] in_now_tick,
  // event output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [kpld_pkg::KPLD_MASK_W-1:0] out_pressed_mask,
  output logic [kpld_pkg::KPLD_MASK_W-1:0] out_released_mask,
  output logic [kpld_pkg::KPLD_MASK_W-1:0] out_long_mask,
  // APB-style register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [kpld_pkg::KPLD_ADDR_W-1:0] paddr,
  input  logic [kpld_pkg::KPLD_DATA_W-1:0] pwdata,
  output logic [kpld_pkg::KPLD_DATA_W-1:0] prdata,
  output logic                             pready
);

  localparam int PW = kpld_pkg::KPLD_PIN_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land in the access phase; pready is tied high.
  // ---------------------------------------------------------------------------
  logic [PW-1:0]                    active_high_r;
  logic                             debounce_en_r;
  logic [kpld_pkg::KPLD_TICK_W-1:0] debounce_ticks_r;
  logic [kpld_pkg::KPLD_TICK_W-1:0] long_ticks_r;
  logic                             cfg_wr;
  kpld_pkg::reg_idx_t               reg_idx;
  kpld_pkg::cfg_t                   lane_cfg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = kpld_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_high_r    <= '0;
      debounce_en_r    <= 1'b0;
      debounce_ticks_r <= kpld_pkg::KPLD_DEBOUNCE_RST;
      long_ticks_r     <= kpld_pkg::KPLD_LONG_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        kpld_pkg::REG_ACTIVE_HIGH: active_high_r    <= pwdata[PW-1:0];
        kpld_pkg::REG_DEBOUNCE_EN: debounce_en_r    <= pwdata[0];
        kpld_pkg::REG_DEBOUNCE_TK: debounce_ticks_r <= pwdata;
        kpld_pkg::REG_LONG_TK:     long_ticks_r     <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back: zero-extend the narrow registers.
  always_comb begin
    case (reg_idx)
      kpld_pkg::REG_ACTIVE_HIGH: prdata = {{(kpld_pkg::KPLD_DATA_W-PW){1'b0}}, active_high_r};
      kpld_pkg::REG_DEBOUNCE_EN: prdata = {{(kpld_pkg::KPLD_DATA_W-1){1'b0}}, debounce_en_r};
      kpld_pkg::REG_DEBOUNCE_TK: prdata = debounce_ticks_r;
      kpld_pkg::REG_LONG_TK:     prdata = long_ticks_r;
      default:                   prdata = '0;
    endcase
  end

  assign lane_cfg.debounce_en    = debounce_en_r;
  assign lane_cfg.debounce_ticks = debounce_ticks_r;
  assign lane_cfg.long_ticks     = long_ticks_r;

  // ---------------------------------------------------------------------------
  // Scan acceptance. Stall only when the skid entry is occupied, so a scan is
  // still taken while one finished result waits on a stalled output.
  // ---------------------------------------------------------------------------
  logic                           skid_full;
  logic                           scan_fire;
  kpld_pkg::evt_t [NUM_KEYS-1:0]  lane_evt;

  assign in_stall  = skid_full;
  assign scan_fire = in_valid & ~skid_full;

  // ---------------------------------------------------------------------------
  // One lane per key, all advancing on the same scan. Keys past the pin field
  // see level 0 with active-low polarity.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic lvl, pol;
    if (k < PW) begin : g_pin
      assign lvl = in_pin_levels[k];
      assign pol = active_high_r[k];
    end else begin : g_nopin
      assign lvl = 1'b0;
      assign pol = 1'b0;
    end

    kpld_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .scan_fire (scan_fire),
      .level     (lvl),
      .polarity  (pol),
      .now_tick  (in_now_tick),
      .cfg       (lane_cfg),
      .evt       (lane_evt[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Merge lane events into the masks and buffer the result.
  // ---------------------------------------------------------------------------
  kpld_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .scan_fire         (scan_fire),
    .lane_evt          (lane_evt),
    .skid_full         (skid_full),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pressed_mask  (out_pressed_mask),
    .out_released_mask (out_released_mask),
    .out_long_mask     (out_long_mask)
  );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for key_press_long_press_detector_unit: directed and random key scans,
// each event transaction checked against a per-key phase predictor kept in the bench.
// Depends on kpld_pkg and the detector top level in rtl/core.
module tb_top;

  localparam int TICK_W = kpld_pkg::KPLD_TICK_W;
  localparam int PIN_W  = kpld_pkg::KPLD_PIN_W;
  localparam int MASK_W = kpld_pkg::KPLD_MASK_W;
  localparam int DATA_W = kpld_pkg::KPLD_DATA_W;
  localparam int ADDR_W = kpld_pkg::KPLD_ADDR_W;
  localparam int NKEYS  = kpld_pkg::KPLD_NUM_KEYS;

  // Quiet cycles (no transaction on either channel) before the run is declared hung.
  // Worst legitimate gap is a run of config writes or a random stall burst.
  localparam int WATCHDOG_LIMIT = 2000;
  // Margin after draining so the registered output can settle.
  localparam int SETTLE_CYCLES  = 4;

  typedef struct packed {
    logic [MASK_W-1:0] pressed;
    logic [MASK_W-1:0] released;
    logic [MASK_W-1:0] long_ev;
  } key_events_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic              clk;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [PIN_W-1:0]  in_pin_levels = '0;
  logic [TICK_W-1:0] in_now_tick   = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [MASK_W-1:0] out_pressed_mask;
  logic [MASK_W-1:0] out_released_mask;
  logic [MASK_W-1:0] out_long_mask;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [DATA_W-1:0] pwdata        = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  key_press_long_press_detector_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pin_levels    (in_pin_levels),
    .in_now_tick      (in_now_tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pressed_mask (out_pressed_mask),
    .out_released_mask(out_released_mask),
    .out_long_mask    (out_long_mask),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: shadow registers and per-key phase machines
  // ---------------------------------------------------------------------------
  logic [MASK_W-1:0]  set_active_high;
  logic               set_debounce_en;
  logic [TICK_W-1:0]  set_debounce_ticks;
  logic [TICK_W-1:0]  set_long_ticks;
  kpld_pkg::phase_t   key_state [NKEYS];
  logic [TICK_W-1:0]  key_stamp [NKEYS];

  key_events_t        expected_events [$];
  key_events_t        head_ev;
  int unsigned        error_count    = 0;
  int unsigned        quiet_cycles   = 0;
  int unsigned        send_idle_pct  = 0;
  int unsigned        recv_stall_pct = 0;
  logic [TICK_W-1:0]  scan_tick      = '0;

  function automatic void reset_key_model();
    set_active_high    = '0;
    set_debounce_en    = 1'b0;
    set_debounce_ticks = kpld_pkg::KPLD_DEBOUNCE_RST;
    set_long_ticks     = kpld_pkg::KPLD_LONG_RST;
    for (int k = 0; k < NKEYS; k++) begin
      key_state[k] = kpld_pkg::PH_RELEASED;
      key_stamp[k] = '0;
    end
  endfunction

  // Advance every key's phase for one scan and return the events it reports.
  function automatic key_events_t predict_key_events(input logic [PIN_W-1:0]  pins,
                                                     input logic [TICK_W-1:0] now);
    key_events_t       ev;
    logic              down;
    logic [TICK_W-1:0] elapsed;
    ev = '0;
    for (int k = 0; k < NKEYS; k++) begin
      down    = (pins[k] == set_active_high[k]);
      elapsed = now - key_stamp[k];   // wraps modulo 2^32
      case (key_state[k])
        kpld_pkg::PH_RELEASED: begin
          if (down) begin
            key_stamp[k] = now;
            if (set_debounce_en) begin
              key_state[k] = kpld_pkg::PH_PREPRESS;
            end else begin
              key_state[k] = kpld_pkg::PH_PRESSED;
              ev.pressed[k] = 1'b1;
            end
          end
        end
        kpld_pkg::PH_PREPRESS: begin
          // a glitch drops back to released, stamp left alone
          if (!down) begin
            key_state[k] = kpld_pkg::PH_RELEASED;
          end else if (elapsed > set_debounce_ticks) begin
            key_state[k] = kpld_pkg::PH_PRESSED;
            key_stamp[k] = now;
            ev.pressed[k] = 1'b1;
          end
        end
        default: begin
          if (!down) begin
            key_state[k] = kpld_pkg::PH_RELEASED;
            key_stamp[k] = '0;
            ev.released[k] = 1'b1;
          end else if (key_state[k] == kpld_pkg::PH_PRESSED && elapsed > set_long_ticks) begin
            key_state[k] = kpld_pkg::PH_LONG;
            key_stamp[k] = now;
            ev.long_ev[k] = 1'b1;
          end
        end
      endcase
    end
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Offer one scan, hold it until accepted, then record its expected events.
  task automatic send_scan(input logic [PIN_W-1:0]  pins,
                           input logic [TICK_W-1:0] tick);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pin_levels <= pins;
    in_now_tick   <= tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_events.push_back(predict_key_events(pins, tick));
  endtask

  // Drop valid and wait until every expected event transaction has arrived.
  task automatic wait_events_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then release the bus; mirror the write in the predictor.
  task automatic write_reg(input kpld_pkg::reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      kpld_pkg::REG_ACTIVE_HIGH: set_active_high    = value[MASK_W-1:0];
      kpld_pkg::REG_DEBOUNCE_EN: set_debounce_en    = value[0];
      kpld_pkg::REG_DEBOUNCE_TK: set_debounce_ticks = value;
      kpld_pkg::REG_LONG_TK:     set_long_ticks     = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Mostly small thresholds so events actually fire; extremes now and then.
  function automatic logic [TICK_W-1:0] pick_threshold(input int unsigned lo,
                                                       input int unsigned hi);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Compare each accepted event transaction with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event transaction: pressed %h released %h long %h",
               out_pressed_mask, out_released_mask, out_long_mask);
        error_count++;
      end else begin
        head_ev = expected_events.pop_front();
        if (out_pressed_mask !== head_ev.pressed) begin
          $error("pressed_mask: expected %h, actual %h", head_ev.pressed, out_pressed_mask);
          error_count++;
        end
        if (out_released_mask !== head_ev.released) begin
          $error("released_mask: expected %h, actual %h",
                 head_ev.released, out_released_mask);
          error_count++;
        end
        if (out_long_mask !== head_ev.long_ev) begin
          $error("long_mask: expected %h, actual %h", head_ev.long_ev, out_long_mask);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: active low, no debounce, long press after more than 1000 ticks.
  task automatic test_default_settings();
    send_scan(4'hF, 32'd0);       // all up
    send_scan(4'h0, 32'd5);       // all pressed at once
    send_scan(4'h0, 32'd1005);    // exactly the long time: nothing
    send_scan(4'h0, 32'd1006);    // one tick past: long press
    send_scan(4'h0, 32'd5000);    // long press reported only once
    send_scan(4'hA, 32'd5001);    // keys 1 and 3 let go
    send_scan(4'hF, 32'd5002);    // keys 0 and 2 let go
  endtask

  // Debounce wait across the tick wrap, glitch in pre-press, and debounce
  // switched off while a key waits in pre-press.
  task automatic test_debounce_and_wrap();
    wait_events_drained();
    write_reg(kpld_pkg::REG_ACTIVE_HIGH, 32'hF);
    write_reg(kpld_pkg::REG_DEBOUNCE_EN, 32'd1);
    write_reg(kpld_pkg::REG_DEBOUNCE_TK, 32'd3);
    write_reg(kpld_pkg::REG_LONG_TK, 32'd0);
    send_scan(4'hF, 32'hFFFF_FFFE);   // enter pre-press just before the wrap
    send_scan(4'hF, 32'd1);           // elapsed 3: still waiting
    send_scan(4'hF, 32'd2);           // elapsed 4: press
    send_scan(4'hF, 32'd2);           // zero elapsed, long time 0: nothing
    send_scan(4'hF, 32'd3);           // long press
    send_scan(4'h0, 32'd4);           // release all
    send_scan(4'h1, 32'd10);          // key 0 into pre-press
    send_scan(4'h0, 32'd11);          // glitch: back to released, no event
    send_scan(4'h1, 32'd12);          // pre-press again
    wait_events_drained();
    write_reg(kpld_pkg::REG_DEBOUNCE_EN, 32'd0);
    send_scan(4'h1, 32'd15);          // pending wait still runs: elapsed 3, nothing
    send_scan(4'h1, 32'd16);          // press
    send_scan(4'h3, 32'd17);          // key 1 pressed at once, key 0 long press
    send_scan(4'h0, 32'd18);          // release both
  endtask

  // Thresholds at all ones never fire; zero debounce fires on any elapsed tick.
  task automatic test_extreme_thresholds();
    wait_events_drained();
    write_reg(kpld_pkg::REG_ACTIVE_HIGH, 32'h5);   // mixed polarity: 4'h5 is all down
    write_reg(kpld_pkg::REG_DEBOUNCE_EN, 32'd1);
    write_reg(kpld_pkg::REG_DEBOUNCE_TK, 32'hFFFF_FFFF);
    write_reg(kpld_pkg::REG_LONG_TK, 32'hFFFF_FFFF);
    send_scan(4'hA, 32'd0);
    send_scan(4'h5, 32'd100);
    send_scan(4'h5, 32'd99);          // largest elapsed, still not greater
    wait_events_drained();
    write_reg(kpld_pkg::REG_DEBOUNCE_TK, 32'd0);
    send_scan(4'h5, 32'd99);          // press
    send_scan(4'h5, 32'd98);          // largest elapsed vs long time: nothing
    send_scan(4'hA, 32'd98);          // release all
  endtask

  // Segments of held-key traffic with glitches and noise, new settings per segment.
  task automatic test_random_scans(input int unsigned n_scans);
    int unsigned       sent;
    int unsigned       seg_len;
    int unsigned       pick;
    int unsigned       bit_idx;
    logic [MASK_W-1:0] held;
    logic [PIN_W-1:0]  pins;
    logic [DATA_W-1:0] value;
    sent = 0;
    held = '0;
    while (sent < n_scans) begin
      // settings change only with nothing in flight
      wait_events_drained();
      pick  = $urandom_range(0, 3);
      value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hF : $urandom;
      write_reg(kpld_pkg::REG_ACTIVE_HIGH, value);
      write_reg(kpld_pkg::REG_DEBOUNCE_EN, $urandom_range(0, 1));
      write_reg(kpld_pkg::REG_DEBOUNCE_TK, pick_threshold(1, 30));
      write_reg(kpld_pkg::REG_LONG_TK, pick_threshold(5, 200));
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        scan_tick = $urandom;
      end else if (pick == 1) begin
        scan_tick = 32'hFFFF_FFFF - $urandom_range(0, 300);   // run across the wrap
      end
      seg_len = $urandom_range(40, 120);
      for (int n = 0; n < seg_len && sent < n_scans; n++) begin
        // hold off now and then until the pipe is empty
        if (n == seg_len / 2 && $urandom_range(0, 2) == 0) wait_events_drained();
        for (int k = 0; k < MASK_W; k++) begin
          if ($urandom_range(0, 99) < 8) held[k] = ~held[k];
        end
        pins = ~(held ^ set_active_high);
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          value = $urandom;
          pins  = value[PIN_W-1:0];
        end else if (pick < 10) begin
          bit_idx = $urandom_range(0, PIN_W - 1);
          pins[bit_idx] = ~pins[bit_idx];
        end
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          scan_tick = $urandom;
        end else begin
          scan_tick = scan_tick + $urandom_range(0, 25);
        end
        send_scan(pins, scan_tick);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_key_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 7;
    recv_stall_pct = 76;
    test_default_settings();
    test_debounce_and_wrap();
    test_extreme_thresholds();
    test_random_scans(550);

    send_idle_pct  = 76;
    recv_stall_pct = 7;
    test_random_scans(550);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_scans(550);

    wait_events_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_events.size() != 0) begin
      $error("%0d event transactions never arrived", expected_events.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
